@@ rtl/mhpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and codes for the min-heap priority queue: transaction
// payloads, command and status codes, signals between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DEF_KEY_BITS = 16;

  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] key;
    logic [7:0]  symbol;
  } cmd_t;

  typedef struct packed {
    logic [15:0] out_key;
    logic [7:0]  out_symbol;
    logic [1:0]  status;
    logic [4:0]  entry_count;
  } rsp_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_INS_INIT,
    OP_FULL,
    OP_EXT_READ,
    OP_EMPTY,
    OP_CLEAR,
    OP_NOOP,
    OP_RD_PARENT,
    OP_INS_STEP,
    OP_EXT_LOAD,
    OP_SIFT_READ,
    OP_SIFT_STEP,
    OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    logic empty;      // no entries held
    logic full;       // count at capacity
    logic ins_move;   // parent larger than new key, shift it down
    logic sift_move;  // a child is smaller than the moving entry
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/mhpq_datapath.sv @@
// ----------------------------------------------------------------------------
// mhpq_datapath
// Heap storage (key and symbol memories, two registered read ports, one
// write port), position and count registers, sift compare and result latch.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_datapath #(
  parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = mhpq_pkg::DEF_KEY_BITS
) (
  input  wire               clk,
  input  wire               rst,
  input  mhpq_pkg::dp_op_t  op,
  input  mhpq_pkg::cmd_t    cmd,
  output mhpq_pkg::dp_stat_t stat,
  output mhpq_pkg::rsp_t    rsp
);
  import mhpq_pkg::*;

  localparam int AW    = $clog2(CAPACITY + 1);
  localparam int DEPTH = 1 << AW;

  // 1-based heap order, slot 0 unused
  logic [KEY_BITS-1:0] mem_key [DEPTH];
  logic [7:0]          mem_sym [DEPTH];

  logic [KEY_BITS-1:0] rd_a_key, rd_b_key;
  logic [7:0]          rd_a_sym, rd_b_sym;
  logic [AW-1:0]       addr_a, addr_b;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [KEY_BITS-1:0] wr_key;
  logic [7:0]          wr_sym;

  logic [AW-1:0]       pos;
  logic [AW-1:0]       count;
  logic [KEY_BITS-1:0] cur_key;
  logic [7:0]          cur_sym;
  logic [KEY_BITS-1:0] res_key;
  logic [7:0]          res_sym;
  logic [1:0]          res_status;

  logic [AW:0]         left_idx, right_idx;
  logic                left_ok, right_ok, take_left, take_right;
  logic [KEY_BITS-1:0] best_key;

  assign left_idx  = {pos, 1'b0};
  assign right_idx = {pos, 1'b1};
  assign left_ok   = left_idx  <= {1'b0, count};
  assign right_ok  = right_idx <= {1'b0, count};

  // Left first if smaller, then right if smaller still; ties never move
  always_comb begin
    take_left  = left_ok && (rd_a_key < cur_key);
    best_key   = take_left ? rd_a_key : cur_key;
    take_right = right_ok && (rd_b_key < best_key);
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = ({1'b0, count} >= (AW+1)'(CAPACITY));
  assign stat.ins_move  = (pos != AW'(1)) && (rd_a_key > cur_key);
  assign stat.sift_move = take_left || take_right;

  always_comb begin
    case (op)
      OP_RD_PARENT: addr_a = pos >> 1;
      OP_EXT_READ:  addr_a = AW'(1);
      default:      addr_a = left_idx[AW-1:0];
    endcase
    addr_b = (op == OP_EXT_READ) ? count : right_idx[AW-1:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos;
    wr_key  = cur_key;
    wr_sym  = cur_sym;
    case (op)
      OP_INS_STEP: begin
        wr_en = 1'b1;
        if (stat.ins_move) begin
          wr_key = rd_a_key;
          wr_sym = rd_a_sym;
        end
      end
      OP_SIFT_STEP: begin
        wr_en = 1'b1;
        if (take_right) begin
          wr_key = rd_b_key;
          wr_sym = rd_b_sym;
        end else if (take_left) begin
          wr_key = rd_a_key;
          wr_sym = rd_a_sym;
        end
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr] <= wr_key;
      mem_sym[wr_addr] <= wr_sym;
    end
    rd_a_key <= mem_key[addr_a];
    rd_a_sym <= mem_sym[addr_a];
    rd_b_key <= mem_key[addr_b];
    rd_b_sym <= mem_sym[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (op)
        OP_CLEAR:    count <= '0;
        OP_EXT_LOAD: count <= count - AW'(1);
        OP_INS_STEP: begin
          if (!stat.ins_move) count <= count + AW'(1);
        end
        default:     count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_INS_INIT: begin
        cur_key    <= KEY_BITS'(cmd.key);
        cur_sym    <= cmd.symbol;
        pos        <= count + AW'(1);
        res_key    <= '0;
        res_sym    <= '0;
        res_status <= ST_OK;
      end
      OP_FULL: begin
        res_key    <= '0;
        res_sym    <= '0;
        res_status <= ST_FULL;
      end
      OP_EMPTY: begin
        res_key    <= '0;
        res_sym    <= '0;
        res_status <= ST_EMPTY;
      end
      OP_EXT_READ, OP_CLEAR, OP_NOOP: begin
        res_key    <= '0;
        res_sym    <= '0;
        res_status <= ST_OK;
      end
      OP_INS_STEP: begin
        if (stat.ins_move) pos <= pos >> 1;
      end
      OP_EXT_LOAD: begin
        res_key <= rd_a_key;
        res_sym <= rd_a_sym;
        cur_key <= rd_b_key;
        cur_sym <= rd_b_sym;
        pos     <= AW'(1);
      end
      OP_SIFT_STEP: begin
        if (take_right) pos <= right_idx[AW-1:0];
        else if (take_left) pos <= left_idx[AW-1:0];
      end
      OP_PUBLISH: begin
        rsp.out_key     <= 16'(res_key);
        rsp.out_symbol  <= res_sym;
        rsp.status      <= res_status;
        rsp.entry_count <= 5'(count);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/mhpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Controller state machine: decodes commands, sequences sift steps in the
// datapath and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                cmd_valid,
  output logic               cmd_ready,
  input  wire [1:0]          command,
  output logic               rsp_valid,
  input  wire                rsp_ready,
  input  mhpq_pkg::dp_stat_t stat,
  output mhpq_pkg::dp_op_t   op
);
  import mhpq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INS_RD    = 7'b0000010,
    S_INS_STEP  = 7'b0000100,
    S_EXT_LOAD  = 7'b0001000,
    S_SIFT_RD   = 7'b0010000,
    S_SIFT_STEP = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign cmd_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (command)
            CMD_INSERT: begin
              op         = stat.full ? OP_FULL : OP_INS_INIT;
              state_next = stat.full ? S_DONE : S_INS_RD;
            end
            CMD_EXTRACT: begin
              op         = stat.empty ? OP_EMPTY : OP_EXT_READ;
              state_next = stat.empty ? S_DONE : S_EXT_LOAD;
            end
            CMD_CLEAR: begin
              op         = OP_CLEAR;
              state_next = S_DONE;
            end
            default: begin
              op         = OP_NOOP;
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        op         = OP_RD_PARENT;
        state_next = S_INS_STEP;
      end
      S_INS_STEP: begin
        op         = OP_INS_STEP;
        state_next = stat.ins_move ? S_INS_RD : S_DONE;
      end
      S_EXT_LOAD: begin
        op         = OP_EXT_LOAD;
        state_next = S_SIFT_RD;
      end
      S_SIFT_RD: begin
        op         = OP_SIFT_READ;
        state_next = S_SIFT_STEP;
      end
      S_SIFT_STEP: begin
        op         = OP_SIFT_STEP;
        state_next = stat.sift_move ? S_SIFT_RD : S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          op         = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_PUBLISH) rsp_valid <= 1'b1;
      else if (rsp_ready)   rsp_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/min_heap_priority_queue.sv @@
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of (key, symbol) pairs with insert, extract-min and clear.
// ----------------------------------------------------------------------------
// Flow: insert loops parent read and step states until the key settles; extract
//   loads root and last entry, then loops sift read and step states; clear,
//   no-op, full and empty go straight to done, which waits out an untaken response.
// Throughput: one transaction at a time; the next command is taken the cycle
//   after the response is loaded.
// Reset: rst clears count, controller state and response valid, not the heap.
`default_nettype none

module min_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY,  // 2 .. 31 entries, entry_count is 5 bits
  parameter int KEY_BITS = mhpq_pkg::DEF_KEY_BITS   // stored key width
) (
  input  wire             clk,
  input  wire             rst,
  // command channel
  input  wire             cmd_valid,
  output logic            cmd_ready,
  input  mhpq_pkg::cmd_t  cmd,
  // response channel, one transaction per command
  output logic            rsp_valid,
  input  wire             rsp_ready,
  output mhpq_pkg::rsp_t  rsp
);
  import mhpq_pkg::*;

  dp_op_t   op;    // per-cycle datapath operation
  dp_stat_t stat;  // count and compare flags back to the controller

  // Controller: accepts a command only when idle, walks the sift loop one
  // level per read state and step state, then publishes into the response
  // register. The response register frees the command side while a result waits.
  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (cmd.command),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .op        (op)
  );

  // Datapath: key/symbol memories with two registered read ports (parent,
  // or both children at once) and one write port; sift-up shifts parents
  // down into the hole, sift-down moves the smaller child up.
  mhpq_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the min-heap priority queue: a tracker mirrors the
// heap, predicts every response and checks the responses in order, while the
// command and response sides stall at random.
// ----------------------------------------------------------------------------

module tb;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH = DEF_CAPACITY;
  localparam logic [1:0] CMD_UNUSED = 2'd3;  // spare code, block treats it as a no-op
  localparam int IDLE_LIMIT = 2000;          // cycles with no transaction on either side
  localparam int RANDOM_ITEMS = 1430;

  // --------------------------------------------------------------------------
  // Heap tracker: keeps its own copy of the heap, turns each accepted command
  // into the response it must produce, and compares responses in order.
  // --------------------------------------------------------------------------
  class heap_tracker;
    logic [15:0] keys[1:HEAP_DEPTH];
    logic [7:0]  syms[1:HEAP_DEPTH];
    int          held;
    rsp_t        awaited[$];
    int          mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    // Work the command against the tracked heap, return the response due.
    function rsp_t predict_response(cmd_t c);
      rsp_t        r;
      int          pos;
      int          best;
      int          left;
      bit          settled;
      logic [15:0] k;
      logic [7:0]  s;
      r = '0;
      case (c.command)
        CMD_INSERT: begin
          if (held >= HEAP_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            // climb while the parent is strictly larger
            pos = held + 1;
            while (pos > 1 && keys[pos / 2] > c.key) begin
              keys[pos] = keys[pos / 2];
              syms[pos] = syms[pos / 2];
              pos = pos / 2;
            end
            keys[pos] = c.key;
            syms[pos] = c.symbol;
            held++;
          end
        end
        CMD_EXTRACT: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.out_key = keys[1];
            r.out_symbol = syms[1];
            keys[1] = keys[held];
            syms[1] = syms[held];
            held--;
            // sink: left child if strictly smaller, right if smaller still
            pos = 1;
            settled = 1'b0;
            while (!settled) begin
              best = pos;
              left = 2 * pos;
              if (left <= held && keys[left] < keys[best]) best = left;
              if (left + 1 <= held && keys[left + 1] < keys[best]) best = left + 1;
              if (best == pos) begin
                settled = 1'b1;
              end else begin
                k = keys[best];
                s = syms[best];
                keys[best] = keys[pos];
                syms[best] = syms[pos];
                keys[pos] = k;
                syms[pos] = s;
                pos = best;
              end
            end
          end
        end
        CMD_CLEAR: held = 0;
        default: ;
      endcase
      r.entry_count = held[4:0];
      return r;
    endfunction

    function void note_command(cmd_t c);
      awaited.push_back(predict_response(c));
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: response with none awaited: key=%h sym=%h st=%0d cnt=%0d",
                   got.out_key, got.out_symbol, got.status, got.entry_count);
        return;
      end
      want = awaited.pop_front();
      if (got.out_key !== want.out_key || got.out_symbol !== want.out_symbol ||
          got.status !== want.status || got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: exp key=%h sym=%h st=%0d cnt=%0d, got key=%h sym=%h st=%0d cnt=%0d",
                   want.out_key, want.out_symbol, want.status, want.entry_count,
                   got.out_key, got.out_symbol, got.status, got.entry_count);
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  heap_tracker tracker = new();
  int idle_cycles = 0;

  min_heap_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Command side. Called at a rising edge; returns at the edge where the
  // transaction is accepted. Valid only drops when a gap follows, so a
  // back-to-back transaction never sees valid lowered and raised in one step.
  // Signals are sampled right after the edge, i.e. their pre-edge values.
  // --------------------------------------------------------------------------
  task automatic send_command(input logic [1:0] op, input logic [15:0] k,
                              input logic [7:0] s, input int gap);
    cmd_t c;
    c.command = op;
    c.key = k;
    c.symbol = s;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    tracker.note_command(c);
  endtask

  // Hold off new commands until the heap has answered everything sent so far.
  task automatic drain_responses();
    cmd_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
  endtask

  // Mostly tiny keys so ties are common, plus the full range and the top end.
  function automatic logic [15:0] pick_key();
    case ($urandom_range(0, 3))
      0, 1:    return 16'($urandom_range(0, 7));
      2:       return 16'($urandom_range(0, 65535));
      default: return 16'hFFF8 + 16'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [1:0] pick_op(int insert_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 2) return CMD_CLEAR;
    if (roll < 4) return CMD_UNUSED;
    if (roll < 4 + insert_pct) return CMD_INSERT;
    return CMD_EXTRACT;
  endfunction

  function automatic int sender_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 13);
  endfunction

  // --------------------------------------------------------------------------
  // Response side: random stall before each transaction, with stretches of
  // continuous ready. Ready stays up while waiting for valid.
  // --------------------------------------------------------------------------
  initial begin : response_sink
    int  stall;
    int  taken;
    bit  burst;
    taken = 0;
    burst = 1'b0;
    rsp_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 30 == 0) burst = ($urandom_range(0, 3) == 0);
      stall = burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
      tracker.check_response(rsp);
      taken++;
    end
  end

  // Watchdog: any transaction on either side resets the count.
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int  n;
    int  insert_pct;
    bit  burst;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty extract, spare code, key/symbol extremes, equal keys,
    // fill to capacity, insert when full, drain a few, clear, empty again.
    send_command(CMD_EXTRACT, 16'h0000, 8'h00, $urandom_range(0, 13));
    send_command(CMD_UNUSED, 16'hFFFF, 8'hFF, $urandom_range(0, 13));
    send_command(CMD_INSERT, 16'hFFFF, 8'hFF, $urandom_range(0, 13));
    send_command(CMD_INSERT, 16'h0000, 8'h00, $urandom_range(0, 13));
    for (n = 0; n < 5; n++)
      send_command(CMD_INSERT, 16'h8000, 8'(8'h40 + n), 0);
    for (n = 0; n < 9; n++)
      send_command(CMD_INSERT, 16'(16'h9000 - n * 16'h0800), 8'(8'hA0 + n),
                   $urandom_range(0, 13));
    send_command(CMD_INSERT, 16'h0001, 8'h77, 0);  // heap is full here
    for (n = 0; n < 3; n++)
      send_command(CMD_EXTRACT, 16'hFFFF, 8'hFF, $urandom_range(0, 2));
    send_command(CMD_CLEAR, 16'h1234, 8'h56, $urandom_range(0, 13));
    send_command(CMD_EXTRACT, 16'h0000, 8'h00, 0);
    drain_responses();

    // Random: phases lean toward filling, draining or a balance so the heap
    // swings between empty and full.
    insert_pct = 48;
    burst = 1'b0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 80;
          1:       insert_pct = 20;
          default: insert_pct = 48;
        endcase
        burst = ($urandom_range(0, 3) == 0);
      end
      if (n % 350 == 349) drain_responses();
      send_command(pick_op(insert_pct), pick_key(), 8'($urandom_range(0, 255)),
                   sender_gap(burst));
    end
    cmd_valid <= 1'b0;

    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
